// ===== hdl/bppe_pkg.sv =====
// Package: widths, limits and controller/datapath signal groups for the envelope block.
package bppe_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int ENV_W      = 16;
	localparam int SIZE_W     = 7;
	localparam int MAX_BLOCK  = 64;
	localparam int RESET_SIZE = 44;
	// counts 0..MAX_BLOCK
	localparam int POS_W      = $clog2(MAX_BLOCK + 1);
	// remainder of a division by the block size, plus one bit for the shift
	localparam int REM_W      = $clog2(MAX_BLOCK) + 1;
	// restoring divider: one quotient bit per step over the range difference
	localparam int DIV_STEPS  = ENV_W;
	localparam int STEP_W     = $clog2(DIV_STEPS);

	typedef struct packed {
		logic accept;   // sample transaction this cycle
		logic init;     // form block range and delta, load divider
		logic step;     // one divider step
		logic fix;      // signed floor correction of the delta quotient
		logic load;     // load next result into the output register
	} bppe_cmd_t;

	typedef struct packed {
		logic block_done;  // accepted sample would complete the block
		logic last;        // next result is the last of the block
	} bppe_status_t;

endpackage

// ===== hdl/bppe_if.sv =====
// Handshake channel interfaces for samples in and envelope results out.
interface bppe_sample_if;
	logic                                valid;
	logic                                ready;
	logic signed [bppe_pkg::SAMPLE_W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface bppe_env_if;
	logic                         valid;
	logic                         ready;
	logic [bppe_pkg::ENV_W-1:0]   envelope;
	logic                         last_of_block;

	modport source (output valid, output envelope, output last_of_block, input ready);
	modport sink (input valid, input envelope, input last_of_block, output ready);
endinterface

// ===== hdl/bppe_ctrl.sv =====
// Controller: sequences sample collection, delta division and result emission.
module bppe_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  logic                   out_ready,
	input  bppe_pkg::bppe_status_t status,
	output bppe_pkg::bppe_cmd_t    cmd
);

	localparam logic [2:0] ST_COLLECT = 3'd0;
	localparam logic [2:0] ST_INIT    = 3'd1;
	localparam logic [2:0] ST_DIV     = 3'd2;
	localparam logic [2:0] ST_FIX     = 3'd3;
	localparam logic [2:0] ST_EMIT    = 3'd4;

	logic [2:0]                    state_q;
	logic [bppe_pkg::STEP_W-1:0]   step_q;
	logic                          out_valid_q;
	logic                          slot_free;

	assign in_ready  = (state_q == ST_COLLECT);
	assign out_valid = out_valid_q;
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		cmd        = '0;
		cmd.accept = (state_q == ST_COLLECT) && in_valid;
		cmd.init   = (state_q == ST_INIT);
		cmd.step   = (state_q == ST_DIV);
		cmd.fix    = (state_q == ST_FIX);
		cmd.load   = (state_q == ST_EMIT) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_COLLECT;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			case (state_q)
				ST_COLLECT: begin
					if (in_valid && status.block_done)
						state_q <= ST_INIT;
				end
				ST_INIT: begin
					step_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == bppe_pkg::STEP_W'(bppe_pkg::DIV_STEPS - 1))
						state_q <= ST_FIX;
				end
				ST_FIX: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (slot_free && status.last)
						state_q <= ST_COLLECT;
				end
				default: begin
					state_q <= ST_COLLECT;
				end
			endcase
		end
	end

endmodule

// ===== hdl/bppe_dp.sv =====
// Datapath: block extremes, delta divider and incremental interpolation.
module bppe_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wen,
	input  logic [bppe_pkg::SIZE_W-1:0]          cfg_wdata,
	input  logic signed [bppe_pkg::SAMPLE_W-1:0] sample,
	input  bppe_pkg::bppe_cmd_t                  cmd,
	output bppe_pkg::bppe_status_t               status,
	output logic [bppe_pkg::ENV_W-1:0]           envelope,
	output logic                                 last_of_block
);

	localparam int SW = bppe_pkg::SIZE_W;
	localparam int PW = bppe_pkg::POS_W;
	localparam int RW = bppe_pkg::REM_W;
	localparam int EW = bppe_pkg::ENV_W;

	logic [SW-1:0]                        size_q;
	logic [SW-1:0]                        n_eff;
	logic [PW-1:0]                        pos_q;
	logic signed [bppe_pkg::SAMPLE_W-1:0] max_q, min_q;
	logic [EW-1:0]                        prev_q, cur_q;
	logic [SW-1:0]                        n_q;
	logic                                 neg_q;
	logic [EW-1:0]                        dvd_q;
	logic [RW-1:0]                        rem_q;
	logic signed [EW:0]                   dq_q;
	logic [RW-1:0]                        dr_q;
	logic [EW-1:0]                        q_q;
	logic [RW-1:0]                        r_q;
	logic [PW-1:0]                        k_q;
	logic [EW-1:0]                        env_q;
	logic                                 last_q;

	logic [EW-1:0]                        range;
	logic signed [EW:0]                   delta;
	logic [RW-1:0]                        rem_sh;
	logic                                 qbit;
	logic [RW-1:0]                        rsum;
	logic                                 wrap;
	logic signed [EW+1:0]                 q_next;

	// size zero acts as one, sizes above the limit saturate
	always_comb begin
		if (size_q == '0)
			n_eff = SW'(1);
		else if (size_q > SW'(bppe_pkg::MAX_BLOCK))
			n_eff = SW'(bppe_pkg::MAX_BLOCK);
		else
			n_eff = size_q;
	end

	assign status.block_done = ({1'b0, pos_q} + 1'b1) >= (PW + 1)'(n_eff);
	assign status.last       = (k_q == PW'(n_q - 1'b1));

	assign range  = EW'(max_q - min_q);
	assign delta  = $signed({1'b0, range}) - $signed({1'b0, prev_q});

	assign rem_sh = {rem_q[RW-2:0], dvd_q[EW-1]};
	assign qbit   = rem_sh >= RW'(n_q);

	// acc(k+1) = acc(k) + delta, kept as quotient and remainder of n
	assign rsum   = r_q + dr_q;
	assign wrap   = rsum >= RW'(n_q);
	assign q_next = $signed({2'b00, q_q}) + (EW + 2)'(dq_q) + $signed((EW + 2)'(wrap));

	assign envelope      = env_q;
	assign last_of_block = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SW'(bppe_pkg::RESET_SIZE);
			pos_q  <= '0;
			max_q  <= '0;
			min_q  <= '0;
			prev_q <= '0;
		end else begin
			if (cfg_wen)
				size_q <= cfg_wdata;
			if (cmd.accept) begin
				if (pos_q == '0) begin
					max_q <= sample;
					min_q <= sample;
				end else begin
					if (sample > max_q)
						max_q <= sample;
					if (sample < min_q)
						min_q <= sample;
				end
				pos_q <= status.block_done ? '0 : pos_q + 1'b1;
			end
			if (cmd.load && status.last)
				prev_q <= cur_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.init) begin
			cur_q <= range;
			neg_q <= delta[EW];
			dvd_q <= delta[EW] ? EW'(-delta) : EW'(delta);
			rem_q <= '0;
			n_q   <= n_eff;
			q_q   <= prev_q;
			r_q   <= '0;
			k_q   <= '0;
		end
		if (cmd.step) begin
			rem_q <= qbit ? rem_sh - RW'(n_q) : rem_sh;
			dvd_q <= {dvd_q[EW-2:0], qbit};
		end
		if (cmd.fix) begin
			if (neg_q && rem_q != '0) begin
				dq_q <= -$signed({1'b0, dvd_q}) - $signed((EW + 1)'(1));
				dr_q <= RW'(n_q) - rem_q;
			end else if (neg_q) begin
				dq_q <= -$signed({1'b0, dvd_q});
				dr_q <= '0;
			end else begin
				dq_q <= $signed({1'b0, dvd_q});
				dr_q <= rem_q;
			end
		end
		if (cmd.load) begin
			env_q  <= q_q;
			last_q <= status.last;
			q_q    <= EW'(q_next);
			r_q    <= wrap ? rsum - RW'(n_q) : rsum;
			k_q    <= k_q + 1'b1;
		end
	end

endmodule

// ===== hdl/block_peak_to_peak_envelope.sv =====
// Top level: peak-to-peak envelope detector with interpolated per-sample output.
//
//   channel   dir  payload                         transaction
//   samples   in   sample[15:0] signed             valid & ready
//   results   out  envelope[15:0], last_of_block   valid & ready
//   cfg       in   cfg_wdata[6:0] block size       cfg_wen
//
// Samples are taken one per cycle while a block fills. The sample that
// completes a block starts a 16-step restoring division of the range change
// by the block size, between a setup and a floor-correction step; then the
// block's n results leave at one per cycle while the output is not stalled.
// No sample is taken during division and emission; the output register
// holds under stall. Reset clears all control state and sets block size 44.
module block_peak_to_peak_envelope (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wen,
	input  logic [bppe_pkg::SIZE_W-1:0]     cfg_wdata,
	bppe_sample_if.sink                     samples,
	bppe_env_if.source                      results
);

	bppe_pkg::bppe_cmd_t    cmd;
	bppe_pkg::bppe_status_t status;

	bppe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (samples.valid),
		.in_ready  (samples.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.status    (status),
		.cmd       (cmd)
	);

	bppe_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_wdata     (cfg_wdata),
		.sample        (samples.sample),
		.cmd           (cmd),
		.status        (status),
		.envelope      (results.envelope),
		.last_of_block (results.last_of_block)
	);

endmodule
